### rtl/core/rspn_pkg.sv
package rspn_pkg;

	// Register map (byte offsets on the config port)
	localparam int unsigned PADDR_W = 2;
	localparam logic [PADDR_W-1:0] REG_DEFAULT_RADIX = 2'd0;
	localparam logic [4:0] DEFAULT_RADIX_RST = 5'd10;

	typedef enum logic [1:0] {
		STATUS_DEFAULT = 2'd0,
		STATUS_SUFFIX  = 2'd1,
		STATUS_INVALID = 2'd2
	} status_t;

	// Prefix accumulator slots, one per suffix radix
	typedef enum logic [1:0] {
		SLOT_BIN = 2'd0,
		SLOT_OCT = 2'd1,
		SLOT_DEC = 2'd2,
		SLOT_HEX = 2'd3
	} slot_t;

	localparam int unsigned NUM_SLOTS = 4;
	localparam logic [4:0] SLOT_RADIX [NUM_SLOTS] = '{5'd2, 5'd8, 5'd10, 5'd16};

	// Decoded form of one character
	typedef struct packed {
		logic       hex_ok;
		logic [3:0] digit;
		logic       sfx_ok;
		slot_t      slot;
		logic       last;
	} char_info_t;

endpackage

### rtl/core/rspn_decode.sv
module rspn_decode (
	input  logic [7:0]          char_code,
	input  logic                is_last,
	output rspn_pkg::char_info_t info
);
	import rspn_pkg::*;

	always_comb begin
		info        = '0;
		info.last   = is_last;
		info.slot   = SLOT_BIN;

		if (char_code >= "0" && char_code <= "9") begin
			info.hex_ok = 1'b1;
			info.digit  = 4'(char_code - "0");
		end else if (char_code >= "a" && char_code <= "f") begin
			info.hex_ok = 1'b1;
			info.digit  = 4'(char_code - "a" + 8'd10);
		end else if (char_code >= "A" && char_code <= "F") begin
			info.hex_ok = 1'b1;
			info.digit  = 4'(char_code - "A" + 8'd10);
		end

		unique case (char_code) inside
			"D", "d", ".": begin
				info.sfx_ok = 1'b1;
				info.slot   = SLOT_DEC;
			end
			"O", "o", "Q", "q": begin
				info.sfx_ok = 1'b1;
				info.slot   = SLOT_OCT;
			end
			"B", "b": begin
				info.sfx_ok = 1'b1;
				info.slot   = SLOT_BIN;
			end
			"H", "h": begin
				info.sfx_ok = 1'b1;
				info.slot   = SLOT_HEX;
			end
			default: begin
				info.sfx_ok = 1'b0;
			end
		endcase
	end

endmodule

### rtl/core/rspn_accum.sv
module rspn_accum #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  rspn_pkg::char_info_t info,
	input  logic [4:0]           radix,
	output logic [31:0]          res_value,
	output rspn_pkg::status_t    res_status
);
	import rspn_pkg::*;

	localparam int unsigned VW = VALUE_WIDTH;

	logic [VW-1:0]        def_acc_q;
	logic                 def_ok_q;
	logic [VW-1:0]        pre_acc_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] pre_ok_q;

	logic [VW-1:0]        def_acc_n;
	logic                 def_ok_n;
	logic [VW-1:0]        pre_acc_n [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] pre_ok_n;
	logic [VW-1:0]        sel_acc;

	// one multiply-add per accumulator; slot radixes are constants
	always_comb begin
		def_ok_n  = def_ok_q && info.hex_ok && ({1'b0, info.digit} < radix);
		def_acc_n = VW'(def_acc_q * VW'(radix)) + VW'(info.digit);
		for (int i = 0; i < NUM_SLOTS; i++) begin
			pre_ok_n[i]  = pre_ok_q[i] && info.hex_ok &&
				({1'b0, info.digit} < SLOT_RADIX[i]);
			pre_acc_n[i] = VW'(pre_acc_q[i] * VW'(SLOT_RADIX[i])) + VW'(info.digit);
		end
	end

	// result uses default path including the last char, prefix path without it
	always_comb begin
		sel_acc = pre_acc_q[info.slot];
		if (def_ok_n) begin
			res_value  = 32'(signed'(def_acc_n));
			res_status = STATUS_DEFAULT;
		end else if (info.sfx_ok && pre_ok_q[info.slot]) begin
			res_value  = 32'(signed'(sel_acc));
			res_status = STATUS_SUFFIX;
		end else begin
			res_value  = '0;
			res_status = STATUS_INVALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_acc_q <= '0;
			def_ok_q  <= 1'b1;
			pre_ok_q  <= '1;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				pre_acc_q[i] <= '0;
			end
		end else if (step) begin
			if (info.last) begin
				def_acc_q <= '0;
				def_ok_q  <= 1'b1;
				pre_ok_q  <= '1;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					pre_acc_q[i] <= '0;
				end
			end else begin
				def_acc_q <= def_acc_n;
				def_ok_q  <= def_ok_n;
				pre_ok_q  <= pre_ok_n;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					pre_acc_q[i] <= pre_acc_n[i];
				end
			end
		end
	end

endmodule

### rtl/core/radix_suffix_number_parser_core.sv
// Numeric literal parser with radix suffix. Characters of one token arrive
// one item per cycle, is_last marking the final one; only that final item
// produces a result. The value is built in default_radix (APB register at
// offset 0, reset 10) and, in parallel, the token minus its last character
// is built in radix 2, 8, 10 and 16. A token made only of digits valid in
// default_radix returns status 0; otherwise a final B, O/Q, D/'.' or H (any
// case) picks the suffix radix and a valid prefix returns status 1; anything
// else returns value 0, status 2. Accumulators wrap at VALUE_WIDTH bits and
// the result is sign-extended or truncated to 32 bits.
// Rate: one item per cycle unless in_stall is high. An item passes an input
// register, then the accumulators and the result register. in_stall rises
// only when a last character sits in the input register while the previous
// result is still held by out_stall.
// default_radix may be written only while no token is in flight.
module radix_suffix_number_parser_core #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   char_code,
	input  logic                         is_last,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [31:0]           value,
	output logic [1:0]                   status,
	// config port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rspn_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import rspn_pkg::*;

	logic [4:0]  default_radix_q;

	char_info_t  dec_info;
	char_info_t  info_s1;
	logic        valid_s1;
	logic        advance;
	logic        load_s1;

	logic [31:0] res_value;
	status_t     res_status;
	logic        out_valid_q;
	logic [31:0] value_q;
	status_t     status_q;

	// ---- config register ----
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr == REG_DEFAULT_RADIX) begin
			prdata = {27'd0, default_radix_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_radix_q <= DEFAULT_RADIX_RST;
		end else if (psel && penable && pwrite && pready && paddr == REG_DEFAULT_RADIX) begin
			default_radix_q <= pwdata[4:0];
		end
	end

	// ---- input register (decoded char) ----
	rspn_decode u_decode (
		.char_code (char_code),
		.is_last   (is_last),
		.info      (dec_info)
	);

	// non-last chars always move on; a last char needs room in the result reg
	assign advance  = valid_s1 && (!info_s1.last || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			info_s1 <= dec_info;
		end
	end

	// ---- accumulators ----
	rspn_accum #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.info       (info_s1),
		.radix      (default_radix_q),
		.res_value  (res_value),
		.res_status (res_status)
	);

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && info_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && info_s1.last) begin
			value_q  <= res_value;
			status_q <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = signed'(value_q);
	assign status    = status_q;

endmodule

### rtl/core/rspn_checker.sv
module rspn_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] value,
	input logic [1:0]         status
);
	import rspn_pkg::*;

	// held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(value) && $stable(status))
		else $error("result changed while stalled");

	// an invalid token always reports zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_INVALID |-> value == 32'sd0)
		else $error("invalid token with nonzero value");

	// input backpressure only comes from a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without blocked result");

endmodule

bind radix_suffix_number_parser_core rspn_checker u_rspn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.value     (value),
	.status    (status)
);
